[src/sph_density_accumulator_core_assert.svh]
`ifndef SPH_DENSITY_ACCUMULATOR_CORE_ASSERT_SVH
`define SPH_DENSITY_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SDAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/sdac_pkg.sv]
package sdac_pkg;

    localparam int PosW    = 16;
    localparam int DiffW   = 17;
    localparam int SquareW = 33;
    localparam int SumW    = 34;
    localparam int RootW   = 17;
    localparam int RemW    = RootW + 3;
    localparam int RadiusW = 15;
    localparam int InvW    = 24;
    localparam int ScaleW  = 32;
    localparam int MassW   = 24;
    localparam int DensW   = 32;
    localparam int FracW   = 17;
    localparam int ProdW   = RootW + InvW;
    localparam int AddW    = 40;
    localparam int InDataW = 4 * PosW + MassW;

    localparam logic [FracW-1:0] FracOne = 17'h10000;

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_RADIUS       = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_INV_RADIUS   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_KERNEL_SCALE = 2'd2;

    localparam logic [RadiusW-1:0] RADIUS_RST       = 15'd1638;
    localparam logic [InvW-1:0]    INV_RADIUS_RST   = 24'd655360;
    localparam logic [ScaleW-1:0]  KERNEL_SCALE_RST = 32'd20860000;

    localparam int FIFO_DEPTH_DEF = 4;

    typedef struct packed {
        logic [RadiusW-1:0] radius;
        logic [InvW-1:0]    inv_radius;
        logic [ScaleW-1:0]  kernel_scale;
    } cfg_t;

    typedef struct packed {
        logic             last;
        logic [MassW-1:0] mass;
        logic [SumW-1:0]  dist_sq;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic pop;
        logic emit;
        logic sum_zero;
        logic idle;
    } back_stat_t;

endpackage

[src/sdac_front.sv]
module sdac_front
    import sdac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [InDataW-1:0] in_data,
    input  logic               in_last,
    input  fifo_stat_t         fstat,
    output logic               push,
    output item_t              push_item
);

    logic                    a_valid_reg, a_valid_next;
    logic signed [DiffW-1:0] a_dx_reg, a_dx_next;
    logic signed [DiffW-1:0] a_dy_reg, a_dy_next;
    logic [MassW-1:0]        a_mass_reg, a_mass_next;
    logic                    a_last_reg, a_last_next;

    logic                    b_valid_reg, b_valid_next;
    logic [SquareW-1:0]      b_sqx_reg, b_sqx_next;
    logic [SquareW-1:0]      b_sqy_reg, b_sqy_next;
    logic [MassW-1:0]        b_mass_reg, b_mass_next;
    logic                    b_last_reg, b_last_next;

    logic [PosW-1:0] cx, cy, nx, ny;
    logic signed [2*DiffW-1:0] sqx_full, sqy_full;
    logic b_free, a_free;

    assign cx = in_data[PosW-1:0];
    assign cy = in_data[2*PosW-1:PosW];
    assign nx = in_data[3*PosW-1:2*PosW];
    assign ny = in_data[4*PosW-1:3*PosW];

    assign push   = b_valid_reg && !fstat.full;
    assign b_free = !b_valid_reg || push;
    assign a_free = !a_valid_reg || b_free;
    assign in_ready = a_free;

    assign sqx_full = a_dx_reg * a_dx_reg;
    assign sqy_full = a_dy_reg * a_dy_reg;

    assign push_item.last    = b_last_reg;
    assign push_item.mass    = b_mass_reg;
    assign push_item.dist_sq = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_dx_next    = a_dx_reg;
        a_dy_next    = a_dy_reg;
        a_mass_next  = a_mass_reg;
        a_last_next  = a_last_reg;
        b_valid_next = b_valid_reg;
        b_sqx_next   = b_sqx_reg;
        b_sqy_next   = b_sqy_reg;
        b_mass_next  = b_mass_reg;
        b_last_next  = b_last_reg;

        if (b_free)
        begin
            b_valid_next = a_valid_reg;
            b_sqx_next   = sqx_full[SquareW-1:0];
            b_sqy_next   = sqy_full[SquareW-1:0];
            b_mass_next  = a_mass_reg;
            b_last_next  = a_last_reg;
        end

        if (a_free)
        begin
            a_valid_next = in_valid;
            a_dx_next    = $signed({nx[PosW-1], nx}) - $signed({cx[PosW-1], cx});
            a_dy_next    = $signed({ny[PosW-1], ny}) - $signed({cy[PosW-1], cy});
            a_mass_next  = in_data[InDataW-1:4*PosW];
            a_last_next  = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_dx_reg   <= a_dx_next;
        a_dy_reg   <= a_dy_next;
        a_mass_reg <= a_mass_next;
        a_last_reg <= a_last_next;
        b_sqx_reg  <= b_sqx_next;
        b_sqy_reg  <= b_sqy_next;
        b_mass_reg <= b_mass_next;
        b_last_reg <= b_last_next;
    end

endmodule

[src/sdac_fifo.sv]
module sdac_fifo
    import sdac_pkg::*;
#(
    parameter int Depth = FIFO_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  item_t      push_item,
    input  logic       pop,
    output item_t      pop_item,
    output fifo_stat_t stat
);

    // Depth is a power of two, at least two; pointers carry one wrap bit.
    localparam int PtrW = $clog2(Depth) + 1;

    item_t           mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;

    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);
    assign stat.full  = (wr_ptr_reg[PtrW-1] != rd_ptr_reg[PtrW-1]) &&
                        (wr_ptr_reg[PtrW-2:0] == rd_ptr_reg[PtrW-2:0]);
    assign pop_item   = mem_reg[rd_ptr_reg[PtrW-2:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg[PtrW-2:0]] <= push_item;
        end
    end

endmodule

[src/sdac_back.sv]
module sdac_back
    import sdac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  fifo_stat_t       fstat,
    input  item_t            pop_item,
    output back_stat_t       stat,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [DensW-1:0] out_data
);

    localparam int StW  = 3;
    localparam logic [StW-1:0] ST_IDLE  = 3'd0;
    localparam logic [StW-1:0] ST_SQRT  = 3'd1;
    localparam logic [StW-1:0] ST_QUOT  = 3'd2;
    localparam logic [StW-1:0] ST_CUBE1 = 3'd3;
    localparam logic [StW-1:0] ST_CUBE2 = 3'd4;
    localparam logic [StW-1:0] ST_WGT   = 3'd5;
    localparam logic [StW-1:0] ST_ADD   = 3'd6;
    localparam logic [StW-1:0] ST_ACC   = 3'd7;

    localparam int CntW = $clog2(RootW);
    localparam int QW   = ProdW - 14;

    logic [StW-1:0]     state_reg, state_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [SumW-1:0]    rad_reg, rad_next;
    logic [RemW-1:0]    rem_reg, rem_next;
    logic [RootW-1:0]   root_reg, root_next;
    logic [MassW-1:0]   mass_reg, mass_next;
    logic               last_reg, last_next;
    logic               zero_reg, zero_next;
    logic [ProdW-1:0]   prod_reg, prod_next;
    logic [FracW-1:0]   f_reg, f_next;
    logic [SquareW-1:0] sq_reg, sq_next;
    logic [FracW-1:0]   c_reg, c_next;
    logic [ScaleW-1:0]  w_reg, w_next;
    logic [AddW-1:0]    add_reg, add_next;
    logic [DensW-1:0]   sum_reg, sum_next;
    logic               out_valid_reg, out_valid_next;
    logic [DensW-1:0]   out_data_reg, out_data_next;

    logic [RemW-1:0]                rem_shift, trial;
    logic [QW-1:0]                  quot;
    logic [FracW-1:0]               fval;
    logic [2*FracW-1:0]             f_sq;
    logic [SquareW+FracW-1:0]       cube;
    logic [ScaleW+FracW-1:0]        wprod;
    logic [MassW+ScaleW-1:0]        aprod;
    logic [AddW:0]                  total;
    logic [DensW-1:0]               sat;
    logic                           slot_free;

    // One root bit per cycle: bring down two radicand bits, try 4*root+1.
    assign rem_shift = {rem_reg[RemW-3:0], rad_reg[SumW-1:SumW-2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    assign quot  = prod_reg[ProdW-1:14];
    assign fval  = FracOne - {1'b0, quot[FracW-2:0]};
    assign f_sq  = fval * fval;
    assign cube  = sq_reg * f_reg;
    assign wprod = cfg.kernel_scale * c_reg;
    assign aprod = mass_reg * w_reg;
    assign total = {{(AddW+1-DensW){1'b0}}, sum_reg} + {1'b0, add_reg};
    assign sat   = (|total[AddW:DensW]) ? {DensW{1'b1}} : total[DensW-1:0];

    assign slot_free = !out_valid_reg || out_ready;

    assign stat.pop      = (state_reg == ST_IDLE) && !fstat.empty;
    assign stat.emit     = (state_reg == ST_ACC) && last_reg && slot_free;
    assign stat.sum_zero = (sum_reg == '0);
    assign stat.idle     = (state_reg == ST_IDLE);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        mass_next      = mass_reg;
        last_next      = last_reg;
        zero_next      = zero_reg;
        prod_next      = prod_reg;
        f_next         = f_reg;
        sq_next        = sq_reg;
        c_next         = c_reg;
        w_next         = w_reg;
        add_next       = add_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fstat.empty)
                begin
                    rad_next   = pop_item.dist_sq;
                    mass_next  = pop_item.mass;
                    last_next  = pop_item.last;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rad_next = rad_reg << 2;
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[RootW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[RootW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(RootW - 1))
                begin
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                prod_next  = root_reg * cfg.inv_radius;
                // Zero distance, zero radius and outside the radius all land here.
                zero_next  = (root_reg == '0) ||
                             ({{(RootW-RadiusW){1'b0}}, cfg.radius} <= root_reg);
                state_next = ST_CUBE1;
            end
            ST_CUBE1:
            begin
                // r/radius at or above one means the reciprocal is off: no weight.
                if (|quot[QW-1:FracW-1])
                begin
                    zero_next = 1'b1;
                end
                f_next     = fval;
                sq_next    = f_sq[SquareW-1:0];
                state_next = ST_CUBE2;
            end
            ST_CUBE2:
            begin
                c_next     = cube[2*16+FracW-1:2*16];
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                w_next     = zero_reg ? '0 : wprod[ScaleW+16-1:16];
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                add_next   = aprod[MassW+ScaleW-1:16];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (last_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = sat;
                        sum_next       = '0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    sum_next   = sat;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        mass_reg     <= mass_next;
        last_reg     <= last_next;
        zero_reg     <= zero_next;
        prod_reg     <= prod_next;
        f_reg        <= f_next;
        sq_reg       <= sq_next;
        c_reg        <= c_next;
        w_reg        <= w_next;
        add_reg      <= add_next;
        out_data_reg <= out_data_next;
    end

endmodule

[src/sph_density_accumulator_core.sv]
// 2-D SPH density summation. Neighbors of one target particle stream in on the
// slave side, one transfer each; the transfer with tlast set closes the target,
// and one density word (unsigned Q16.16, saturating) leaves on the master side.
// The front end takes a neighbor every cycle unless a full queue holds it back,
// forms the squared distance in two stages and queues it; the back end handles
// one neighbor at a time and sets the rate: it takes the neighbor from the queue,
// runs the bit-serial square root, then the multiply chain and accumulate,
// and takes no new neighbor until done. A finished density waits in an output
// register while the next neighbors are worked on. Configuration writes are
// taken every cycle and must only be issued while the block is idle.
`include "sph_density_accumulator_core_assert.svh"

module sph_density_accumulator_core
    import sdac_pkg::*;
#(
    parameter int FifoDepth = FIFO_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // center_x[15:0], center_y[31:16], neighbor_x[47:32], neighbor_y[63:48],
    // neighbor_mass[87:64]
    input  logic [InDataW-1:0] s_axis_tdata,
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // density[31:0]
    output logic [DensW-1:0]   m_axis_tdata,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [ScaleW-1:0]  cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    fifo_stat_t fstat;
    back_stat_t bstat;
    logic       push;
    item_t      push_item;
    item_t      pop_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RADIUS:       cfg_next.radius       = cfg_data[RadiusW-1:0];
                CFG_INV_RADIUS:   cfg_next.inv_radius   = cfg_data[InvW-1:0];
                CFG_KERNEL_SCALE: cfg_next.kernel_scale = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius       <= RADIUS_RST;
            cfg_reg.inv_radius   <= INV_RADIUS_RST;
            cfg_reg.kernel_scale <= KERNEL_SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .fstat     (fstat),
        .push      (push),
        .push_item (push_item)
    );

    sdac_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (bstat.pop),
        .pop_item  (pop_item),
        .stat      (fstat)
    );

    sdac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fstat     (fstat),
        .pop_item  (pop_item),
        .stat      (bstat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    `SDAC_ASSERT_IMP(a_pop_nonempty, clk, rst_n, bstat.pop, !fstat.empty)
    `SDAC_ASSERT_NXT(a_emit_clears, clk, rst_n, bstat.emit, bstat.sum_zero)
    `SDAC_ASSERT_NXT(a_back_starts, clk, rst_n, bstat.idle && !fstat.empty, !bstat.idle)

endmodule
